[design/sha_pkg.sv]
// shared types, constants and round functions for the sha-256 message hash core
package sha_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word0;
    logic [63:0] digest_word1;
    logic [63:0] digest_word2;
    logic [63:0] digest_word3;
  } out_item_t;

  // classified beat handed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } cmd_t;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned s);
    ror = (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage

[design/sha_front.sv]
// input stage: drops empty beats and queues the rest for the hash engine
module sha_front #(
  parameter int unsigned QDEPTH = sha_pkg::QueueDepthDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sha_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output sha_pkg::cmd_t     q_cmd
);

  localparam int unsigned AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  sha_pkg::cmd_t     mem [QDEPTH];
  logic [AW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]       cnt_r, cnt_nxt;
  logic              push, pop, keep;

  // a beat with no byte and no end of message does nothing
  assign keep     = in_data.has_byte | in_data.last;
  assign in_ready = (cnt_r != QDEPTH[AW:0]);
  assign push     = in_valid & in_ready & keep;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_valid & q_ready;
  assign q_cmd    = mem[rp_r];

  function automatic logic [AW-1:0] incp(input logic [AW-1:0] p);
    incp = (p == AW'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wp_nxt  = push ? incp(wp_r) : wp_r;
    rp_nxt  = pop ? incp(rp_r) : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= '{data_byte: in_data.data_byte, has_byte: in_data.has_byte,
                     last: in_data.last};
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QDEPTH[AW:0]) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == QDEPTH[AW:0]) |-> !push) else $error("push into full queue");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1)) else $error("count step");

endmodule

[design/sha_back.sv]
// hash engine: packs bytes, pads, runs the 64 rounds and holds the digest
module sha_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  sha_pkg::cmd_t      q_cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output sha_pkg::out_item_t out_data
);

  typedef enum logic [4:0] {
    S_TAKE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_FOLD  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t        st_r, st_nxt;
  logic [31:0]   h_r [8];
  logic [31:0]   blk_r [16];
  logic [31:0]   w_r [16];
  logic [31:0]   v_r [8];
  logic [60:0]   cnt_r;
  logic [5:0]    rnd_r;
  logic          fin_r;    // message ended: padding path active
  logic          len_r;    // next compression carries the length block
  logic          pad_r;    // padded block already issued for this message
  logic          ov_r;

  logic          take;
  logic          len_fit;
  logic [5:0]    pos;
  logic [60:0]   cnt_inc;
  logic [31:0]   wt, x, y, t1, t2;
  logic [63:0]   bits;

  assign q_ready   = (st_r == S_TAKE);
  assign take      = q_valid & q_ready;
  assign out_valid = ov_r;
  assign cnt_inc   = cnt_r + 61'd1;
  assign pos       = cnt_r[5:0];
  assign bits      = {cnt_r, 3'b000};
  assign len_fit   = len_r || (pos < 6'd56);

  always_comb begin
    x  = w_r[4'(rnd_r - 6'd15)];
    y  = w_r[4'(rnd_r - 6'd2)];
    wt = (rnd_r < 6'd16) ? w_r[rnd_r[3:0]] :
         w_r[rnd_r[3:0]] + sha_pkg::ssig0(x) + w_r[4'(rnd_r - 6'd7)] + sha_pkg::ssig1(y);
    t1 = v_r[7] + sha_pkg::bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
       + sha_pkg::RoundK[rnd_r] + wt;
    t2 = sha_pkg::bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_TAKE: begin
        if (take) begin
          if (q_cmd.has_byte && cnt_inc[5:0] == 6'd0) st_nxt = S_ROUND;
          else if (q_cmd.last) st_nxt = S_PAD;
        end
      end
      S_PAD:   st_nxt = S_ROUND;
      S_ROUND: if (rnd_r == 6'd63) st_nxt = S_FOLD;
      S_FOLD: begin
        if (!fin_r) st_nxt = S_TAKE;
        else if (len_r || !pad_r) st_nxt = S_PAD;
        else st_nxt = S_EMIT;
      end
      S_EMIT:  if (!ov_r || out_ready) st_nxt = S_TAKE;
      default: st_nxt = S_TAKE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_TAKE;
      cnt_r <= '0;
      rnd_r <= '0;
      fin_r <= 1'b0;
      len_r <= 1'b0;
      pad_r <= 1'b0;
      ov_r  <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::InitH[i];
    end else begin
      st_r <= st_nxt;
      if (st_r == S_EMIT && (!ov_r || out_ready)) ov_r <= 1'b1;
      else if (ov_r && out_ready) ov_r <= 1'b0;
      case (st_r)
        S_TAKE: begin
          if (take) begin
            if (q_cmd.has_byte) cnt_r <= cnt_inc;
            if (q_cmd.last) fin_r <= 1'b1;
            if (q_cmd.has_byte && cnt_inc[5:0] == 6'd0) begin
              for (int i = 0; i < 15; i++) w_r[i] <= blk_r[i];
              w_r[15] <= {blk_r[15][31:8], q_cmd.data_byte};
              for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
              rnd_r <= '0;
            end
          end
        end
        S_PAD: begin
          // first pass: 0x80 and length if it fits; second: length block only
          for (int i = 0; i < 16; i++) begin
            if (len_fit && i == 14) w_r[i] <= bits[63:32];
            else if (len_fit && i == 15) w_r[i] <= bits[31:0];
            else if (len_r) w_r[i] <= 32'd0;
            else if (i == int'(pos[5:2])) begin
              case (pos[1:0])
                2'd0:    w_r[i] <= {sha_pkg::PadByte, 24'd0};
                2'd1:    w_r[i] <= {blk_r[i][31:24], sha_pkg::PadByte, 16'd0};
                2'd2:    w_r[i] <= {blk_r[i][31:16], sha_pkg::PadByte, 8'd0};
                default: w_r[i] <= {blk_r[i][31:8], sha_pkg::PadByte};
              endcase
            end else if (i < int'(pos[5:2])) w_r[i] <= blk_r[i];
            else w_r[i] <= 32'd0;
          end
          len_r <= !len_fit;
          pad_r <= 1'b1;
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
          rnd_r <= '0;
        end
        S_ROUND: begin
          if (rnd_r >= 6'd16) w_r[rnd_r[3:0]] <= wt;
          v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4]; v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0]; v_r[0] <= t1 + t2;
          rnd_r <= rnd_r + 6'd1;
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
        end
        S_EMIT: begin
          if (!ov_r || out_ready) begin
            fin_r <= 1'b0;
            pad_r <= 1'b0;
            cnt_r <= '0;
            for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::InitH[i];
          end
        end
        default: ;
      endcase
    end
  end

  // byte packing and digest capture carry no reset
  always_ff @(posedge clk) begin
    if (take && q_cmd.has_byte) begin
      case (pos[1:0])
        2'd0:    blk_r[pos[5:2]] <= {q_cmd.data_byte, 24'd0};
        2'd1:    blk_r[pos[5:2]][23:16] <= q_cmd.data_byte;
        2'd2:    blk_r[pos[5:2]][15:8] <= q_cmd.data_byte;
        default: blk_r[pos[5:2]][7:0] <= q_cmd.data_byte;
      endcase
    end
    if (st_r == S_EMIT && (!ov_r || out_ready)) begin
      out_data <= '{digest_word0: {h_r[0], h_r[1]}, digest_word1: {h_r[2], h_r[3]},
                    digest_word2: {h_r[4], h_r[5]}, digest_word3: {h_r[6], h_r[7]}};
    end
  end

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> (st_r == S_TAKE)) else $error("beat taken while busy");
  a_round_run: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_ROUND && rnd_r != 6'd63) |=> (st_r == S_ROUND)) else $error("round cut short");
  a_emit_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EMIT) |-> fin_r) else $error("digest without end of message");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> ov_r && $stable(out_data)) else $error("result dropped");

endmodule

[design/sha256_message_hash_core.sv]
// top level of the byte-fed sha-256 message hash core
//  channel | dir | handshake             | payload
//  in_     | in  | in_valid / in_ready   | in_data  (data_byte, has_byte, last)
//  out_    | out | out_valid / out_ready | out_data (digest_word0..3)
// a byte beat is taken in S_TAKE; the 64th byte of a block runs the 64 rounds, then a fold
// the last beat adds one or two padded blocks (S_PAD, S_ROUND, S_FOLD), then S_EMIT gives the digest
// the round loop is a single shared compression unit, one round per cycle
// rst_n is synchronous; hash state returns to the initial values, queue empties
// input beats queue while the engine is busy; out_ready low holds the digest
module sha256_message_hash_core #(
  parameter int unsigned QDEPTH = sha_pkg::QueueDepthDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sha_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sha_pkg::out_item_t out_data
);

  logic          q_valid, q_ready;
  sha_pkg::cmd_t q_cmd;

  sha_front #(.QDEPTH(QDEPTH)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .q_valid, .q_ready, .q_cmd
  );

  sha_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd, .out_valid, .out_ready, .out_data
  );

endmodule
